// File: src/flash_erase_block_writeback_buffer_top_assert.svh
// Assertion macros used by the back engine RTL.
`ifndef FLASH_ERASE_BLOCK_WRITEBACK_BUFFER_TOP_ASSERT_SVH
`define FLASH_ERASE_BLOCK_WRITEBACK_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FEWB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fewb: same-cycle check failed");

// Next-cycle implication.
`define FEWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fewb: next-cycle check failed");

`endif

// File: src/fewb_pkg.sv
package fewb_pkg;

   localparam int PAGE_BYTES          = 4;
   localparam int DEF_PAGES_PER_BLOCK = 16;
   localparam int DEF_NUM_BLOCKS      = 64;

   localparam int ADDR_W   = 12;
   localparam int BLK_W    = 6;
   localparam int OFF_W    = 6;
   localparam int INDEX_W  = 10;
   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int ACTION_W = 2;
   localparam int KIND_W   = 2;

   localparam int QUEUE_DEPTH = 4;
   // fixed-point shift for the reciprocal used to split address into block/offset
   localparam int DIV_SHIFT   = 20;

   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd2;

   localparam logic [KIND_W-1:0] OP_ERASE   = 2'd0;
   localparam logic [KIND_W-1:0] OP_PROGRAM = 2'd1;
   localparam logic [KIND_W-1:0] OP_DONE    = 2'd2;

   localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   write_data;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0]  op_kind;
      logic [INDEX_W-1:0] flash_index;
      logic [WORD_W-1:0]  page_word;
      logic [BYTE_W-1:0]  read_data;
      logic               last;
   } rsp_payload_type;

   // classified access handed from front to back
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                in_area;
      logic [BLK_W-1:0]    blk;
      logic [OFF_W-1:0]    off;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   write_data;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_RD_WAIT,
      S_WB_ERASE,
      S_WB_RD,
      S_WB_COL,
      S_WB_PROG,
      S_LOAD_RD,
      S_LOAD_WR,
      S_STORE,
      S_DONE
   } back_state_type;

endpackage

// File: src/fewb_chan_if.sv
interface fewb_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/fewb_front.sv
module fewb_front
   import fewb_pkg::*;
#(
   parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK,
   parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   fewb_chan_if.sink   req_chan,
   input  logic        queue_full,
   output logic        push,
   output cmd_type     push_cmd
);

   localparam int BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;
   localparam int AREA_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
   localparam int RECIP       = (1 << DIV_SHIFT) / BLOCK_BYTES;
   localparam int PROD_W      = 32;

   logic                  s1_valid_ff, s1_valid_in;
   req_payload_type       s1_req_ff;
   logic [INDEX_W-1:0]    s1_quot_ff, s1_quot_in;
   logic                  accept;
   logic [PROD_W-1:0]     prod;
   logic [ADDR_W-1:0]     rem_raw;
   logic [ADDR_W-1:0]     rem_fix;
   logic                  fix;
   logic [INDEX_W-1:0]    blk_full;

   assign req_chan.ready = !s1_valid_ff || !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = s1_valid_ff && !queue_full;

   // quotient estimate, low by at most one
   assign prod       = PROD_W'(req_chan.payload.address) * PROD_W'(RECIP);
   assign s1_quot_in = prod[DIV_SHIFT +: INDEX_W];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_chan.payload;
         s1_quot_ff <= s1_quot_in;
      end
   end

   always_comb begin
      rem_raw  = s1_req_ff.address - ADDR_W'(s1_quot_ff) * ADDR_W'(BLOCK_BYTES);
      fix      = rem_raw >= ADDR_W'(BLOCK_BYTES);
      rem_fix  = fix ? (rem_raw - ADDR_W'(BLOCK_BYTES)) : rem_raw;
      blk_full = s1_quot_ff + INDEX_W'(fix);

      push_cmd.action     = s1_req_ff.action;
      push_cmd.in_area    = {1'b0, s1_req_ff.address} < (ADDR_W + 1)'(AREA_BYTES);
      push_cmd.blk        = blk_full[BLK_W-1:0];
      push_cmd.off        = rem_fix[OFF_W-1:0];
      push_cmd.address    = s1_req_ff.address;
      push_cmd.write_data = s1_req_ff.write_data;
   end

endmodule

// File: src/fewb_queue.sv
module fewb_queue
   import fewb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]     count_ff, count_in;

   assign full  = count_ff == QCW'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/fewb_back.sv
`include "flash_erase_block_writeback_buffer_top_assert.svh"

module fewb_back
   import fewb_pkg::*;
#(
   parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK,
   parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  cmd_type     queue_head,
   output logic        queue_pop,
   fewb_chan_if.source rsp_chan
);

   localparam int BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;
   localparam int AREA_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
   localparam int FA_AW       = $clog2(AREA_BYTES);
   localparam int BUF_AW      = $clog2(BLOCK_BYTES);
   localparam int BLK_AW      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [OFF_W-1:0]        cnt_ff, cnt_in;
   logic [WORD_W-1:0]       word_ff, word_in;
   logic [BYTE_W-1:0]       rdata_ff, rdata_in;
   logic [BLK_W-1:0]        buf_blk_ff, buf_blk_in;
   logic                    valid_ff, valid_in;
   logic                    dirty_ff, dirty_in;
   logic [NUM_BLOCKS-1:0]   prog_ff, prog_in;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_ff, rsp_in;
   logic                    emit;

   logic [BYTE_W-1:0]       flash_mem_ff [AREA_BYTES];
   logic [BYTE_W-1:0]       buf_mem_ff [BLOCK_BYTES];
   logic [BYTE_W-1:0]       fl_q_ff, buf_q_ff;
   logic                    fl_re, fl_we, buf_re, buf_we;
   logic [ADDR_W-1:0]       fl_ra, fl_wa;
   logic [OFF_W-1:0]        buf_ra, buf_wa;
   logic [BYTE_W-1:0]       fl_wd, buf_wd;

   logic                    out_free;
   logic                    hit;
   logic                    cmd_prog;
   logic [ADDR_W-1:0]       wb_base, cmd_base;
   logic [INDEX_W-1:0]      page_index;
   logic                    cnt_last, page_end;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign hit        = valid_ff && (cmd_ff.blk == buf_blk_ff);
   assign cmd_prog   = prog_ff[cmd_ff.blk[BLK_AW-1:0]];
   assign wb_base    = ADDR_W'(buf_blk_ff) * ADDR_W'(BLOCK_BYTES);
   assign cmd_base   = ADDR_W'(cmd_ff.blk) * ADDR_W'(BLOCK_BYTES);
   assign page_index = INDEX_W'(buf_blk_ff) * INDEX_W'(PAGES_PER_BLOCK)
                     + INDEX_W'(cnt_ff[OFF_W-1:2]);
   assign cnt_last   = cnt_ff == OFF_W'(BLOCK_BYTES - 1);
   assign page_end   = cnt_ff[1:0] == 2'(PAGE_BYTES - 1);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (cmd_ff.action)
               ACT_READ: begin
                  state_in = cmd_ff.in_area ? S_RD_WAIT : S_DONE;
               end
               ACT_WRITE: begin
                  if (!cmd_ff.in_area) begin
                     state_in = S_DONE;
                  end else if (valid_ff && dirty_ff && !hit) begin
                     state_in = S_WB_ERASE;
                  end else if (!hit) begin
                     state_in = S_LOAD_RD;
                  end else begin
                     state_in = S_STORE;
                  end
               end
               ACT_COMMIT: begin
                  state_in = (valid_ff && dirty_ff) ? S_WB_ERASE : S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RD_WAIT: state_in = S_DONE;
         S_WB_ERASE: begin
            if (out_free) begin
               state_in = S_WB_RD;
            end
         end
         S_WB_RD: state_in = S_WB_COL;
         S_WB_COL: state_in = page_end ? S_WB_PROG : S_WB_RD;
         S_WB_PROG: begin
            if (out_free) begin
               if (!cnt_last) begin
                  state_in = S_WB_RD;
               end else if (cmd_ff.action == ACT_WRITE) begin
                  state_in = S_LOAD_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_LOAD_RD: state_in = S_LOAD_WR;
         S_LOAD_WR: state_in = cnt_last ? S_STORE : S_LOAD_RD;
         S_STORE: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmd_in     = cmd_ff;
      cnt_in     = cnt_ff;
      word_in    = word_ff;
      rdata_in   = rdata_ff;
      buf_blk_in = buf_blk_ff;
      valid_in   = valid_ff;
      dirty_in   = dirty_ff;
      prog_in    = prog_ff;
      queue_pop  = 1'b0;
      emit       = 1'b0;
      rsp_in     = '0;
      fl_re      = 1'b0;
      fl_ra      = cmd_ff.address;
      fl_we      = 1'b0;
      fl_wa      = wb_base + ADDR_W'(cnt_ff);
      fl_wd      = buf_q_ff;
      buf_re     = 1'b0;
      buf_ra     = cnt_ff;
      buf_we     = 1'b0;
      buf_wa     = cnt_ff;
      buf_wd     = cmd_prog ? fl_q_ff : ERASED_BYTE;
      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               cmd_in    = queue_head;
            end
         end
         S_DISPATCH: begin
            cnt_in   = '0;
            rdata_in = (cmd_ff.action == ACT_READ) ? ERASED_BYTE : '0;
            if (cmd_ff.action == ACT_READ && cmd_ff.in_area) begin
               if (hit) begin
                  buf_re = 1'b1;
                  buf_ra = cmd_ff.off;
               end else begin
                  fl_re = 1'b1;
               end
            end
            // commit with nothing to write back just drops the buffer
            if (cmd_ff.action == ACT_COMMIT && !(valid_ff && dirty_ff)) begin
               valid_in = 1'b0;
               dirty_in = 1'b0;
            end
         end
         S_RD_WAIT: begin
            rdata_in = hit ? buf_q_ff : (cmd_prog ? fl_q_ff : ERASED_BYTE);
         end
         S_WB_ERASE: begin
            if (out_free) begin
               emit                = 1'b1;
               rsp_in.op_kind      = OP_ERASE;
               rsp_in.flash_index  = INDEX_W'(buf_blk_ff);
            end
         end
         S_WB_RD: begin
            buf_re = 1'b1;
         end
         S_WB_COL: begin
            word_in = {buf_q_ff, word_ff[WORD_W-1:BYTE_W]};
            fl_we   = 1'b1;
            if (!page_end) begin
               cnt_in = cnt_ff + OFF_W'(1);
            end
         end
         S_WB_PROG: begin
            if (out_free) begin
               emit               = 1'b1;
               rsp_in.op_kind     = OP_PROGRAM;
               rsp_in.flash_index = page_index;
               rsp_in.page_word   = word_ff;
               if (cnt_last) begin
                  cnt_in   = '0;
                  dirty_in = 1'b0;
                  prog_in[buf_blk_ff[BLK_AW-1:0]] = 1'b1;
                  if (cmd_ff.action != ACT_WRITE) begin
                     valid_in = 1'b0;
                  end
               end else begin
                  cnt_in = cnt_ff + OFF_W'(1);
               end
            end
         end
         S_LOAD_RD: begin
            fl_re = 1'b1;
            fl_ra = cmd_base + ADDR_W'(cnt_ff);
         end
         S_LOAD_WR: begin
            buf_we = 1'b1;
            if (cnt_last) begin
               buf_blk_in = cmd_ff.blk;
               valid_in   = 1'b1;
               dirty_in   = 1'b0;
            end else begin
               cnt_in = cnt_ff + OFF_W'(1);
            end
         end
         S_STORE: begin
            buf_we   = 1'b1;
            buf_wa   = cmd_ff.off;
            buf_wd   = cmd_ff.write_data;
            dirty_in = 1'b1;
         end
         S_DONE: begin
            if (out_free) begin
               emit             = 1'b1;
               rsp_in.op_kind   = OP_DONE;
               rsp_in.read_data = rdata_ff;
               rsp_in.last      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         buf_blk_ff   <= '0;
         valid_ff     <= 1'b0;
         dirty_ff     <= 1'b0;
         prog_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         buf_blk_ff <= buf_blk_in;
         valid_ff   <= valid_in;
         dirty_ff   <= dirty_in;
         prog_ff    <= prog_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      cnt_ff   <= cnt_in;
      word_ff  <= word_in;
      rdata_ff <= rdata_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // flash array; a block never programmed reads as erased via prog_ff
   always_ff @(posedge clock) begin
      if (fl_we) begin
         flash_mem_ff[fl_wa[FA_AW-1:0]] <= fl_wd;
      end
      if (fl_re) begin
         fl_q_ff <= flash_mem_ff[fl_ra[FA_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem_ff[buf_wa[BUF_AW-1:0]] <= buf_wd;
      end
      if (buf_re) begin
         buf_q_ff <= buf_mem_ff[buf_ra[BUF_AW-1:0]];
      end
   end

   `FEWB_ASSERT_SAME(a_last_only_on_done, clock, reset, rsp_valid_ff, rsp_ff.last == (rsp_ff.op_kind == OP_DONE))
   `FEWB_ASSERT_SAME(a_dirty_needs_valid, clock, reset, dirty_ff, valid_ff)
   `FEWB_ASSERT_SAME(a_wb_only_if_dirty, clock, reset, state_ff == S_WB_ERASE, valid_ff && dirty_ff)
   `FEWB_ASSERT_SAME(a_cnt_in_block, clock, reset, state_ff == S_WB_RD || state_ff == S_LOAD_RD, cnt_ff <= OFF_W'(BLOCK_BYTES - 1))
   `FEWB_ASSERT_NEXT(a_done_returns_idle, clock, reset, state_ff == S_DONE && out_free, state_ff == S_IDLE)

endmodule

// File: src/flash_erase_block_writeback_buffer_top.sv
// Channel    Dir  Transaction payload
// req_chan   in   action, address, write_data
// rsp_chan   out  op_kind, flash_index, page_word, read_data, last
//
// Front splits the address into block/offset over two stages and feeds a
// 4-entry queue; the back engine pops one access at a time.
// Read or buffer-hit write: S_IDLE, S_DISPATCH, S_RD_WAIT or S_STORE, then S_DONE.
// Block load steps S_LOAD_RD, S_LOAD_WR per byte; write-back steps S_WB_ERASE,
// then S_WB_RD, S_WB_COL per buffer RAM byte and S_WB_PROG per page.
// Synchronous reset, no clearing pass; rsp stalls hold the engine, req fills the queue.
module flash_erase_block_writeback_buffer_top
   import fewb_pkg::*;
#(
   parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK,
   parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   fewb_chan_if.sink   req_chan,
   fewb_chan_if.source rsp_chan
);

   logic    push, queue_full, queue_pop, queue_empty;
   cmd_type push_cmd, queue_head;

   fewb_front #(
      .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
      .NUM_BLOCKS      (NUM_BLOCKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   fewb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   fewb_back #(
      .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
      .NUM_BLOCKS      (NUM_BLOCKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
